>>> rtl/core/rims_pkg.sv
package rims_pkg;

    localparam int TICK_COUNT_BITS = 16;
    localparam int LIMIT_BITS      = 16;
    localparam int CMP_BITS        = (TICK_COUNT_BITS > LIMIT_BITS) ? TICK_COUNT_BITS
                                                                    : LIMIT_BITS;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(5000);

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_MOVE   = 2'd1,
        MODE_ORIGIN = 2'd2,
        MODE_FREE   = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        ST_ACCEPTED  = 4'd0,
        ST_DONE      = 4'd1,
        ST_MOVING    = 4'd2,
        ST_IDLE      = 4'd3,
        ST_NOT_HOMED = 4'd4,
        ST_ALARM     = 4'd5,
        ST_LIMIT_ON  = 4'd6,
        ST_LIMIT_OFF = 4'd7,
        ST_TIMEOUT   = 4'd8
    } t_status;

    localparam logic [2:0] DRIVE_NONE = 3'd0;
    localparam logic [2:0] DRIVE_MAX  = 3'd4;

    typedef struct packed {
        t_mode      mode;
        logic [1:0] target;
        logic       check_limits;
        logic       at_0;
        logic       at_90;
        logic       at_180;
        logic       at_270;
        logic       in_position;
        logic       alarm;
    } t_in_item;

    typedef struct packed {
        t_status    status;
        logic [1:0] which_target;
        logic [2:0] drive_target;
        logic       drive_origin;
        logic       free_out;
        logic       alarm_reset;
        logic       ready_ok;
    } t_out_item;

    typedef struct packed {
        logic                       homed;
        logic                       moving;
        logic [1:0]                 move_target;
        logic [TICK_COUNT_BITS-1:0] elapsed;
        logic [2:0]                 drive;
        logic                       origin;
        logic                       free;
    } t_state;

endpackage

>>> rtl/core/rims_step.sv
module rims_step
    import rims_pkg::*;
(
    input  t_in_item                 i_item,
    input  t_state                   i_state,
    input  logic [LIMIT_BITS-1:0]    i_limit,
    output t_state                   o_state,
    output t_out_item                o_result
);

    localparam logic [TICK_COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [3:0]                 sens;
    logic [3:0]                 tgt_mask;
    logic                       s_tgt;
    logic                       s_others;
    logic                       s_moved;
    logic [TICK_COUNT_BITS-1:0] el_inc;
    logic                       timed_out;
    logic [2:0]                 tgt_drive;
    t_state                     nxt;
    t_status                    status;
    logic [1:0]                 which;
    logic                       areset;

    assign sens      = {i_item.at_270, i_item.at_180, i_item.at_90, i_item.at_0};
    assign tgt_mask  = 4'b0001 << i_item.target;
    assign s_tgt     = sens[i_item.target];
    assign s_others  = |(sens & ~tgt_mask);
    assign s_moved   = sens[i_state.move_target];
    assign el_inc    = (i_state.elapsed == COUNT_MAX) ? i_state.elapsed
                                                      : i_state.elapsed + 1'b1;
    assign timed_out = CMP_BITS'(el_inc) >= CMP_BITS'(i_limit);
    assign tgt_drive = 3'(i_item.target) + 3'd1;

    always_comb begin
        nxt    = i_state;
        status = ST_IDLE;
        which  = 2'd0;
        areset = 1'b0;
        case (i_item.mode)
            MODE_TICK: begin
                which = i_state.move_target;
                if (i_state.moving) begin
                    nxt.elapsed = el_inc;
                    if (timed_out) begin
                        status = ST_TIMEOUT;
                    end else if (i_item.alarm) begin
                        status = ST_ALARM;
                    end else if (s_moved && i_item.in_position) begin
                        status = ST_DONE;
                    end else begin
                        status = ST_MOVING;
                    end
                    if (status != ST_MOVING) begin
                        nxt.drive  = DRIVE_NONE;
                        nxt.origin = 1'b0;
                        nxt.free   = 1'b0;
                        nxt.moving = 1'b0;
                    end
                end
            end
            MODE_MOVE: begin
                which = i_item.target;
                if (!i_state.homed) begin
                    status = (i_item.check_limits && i_item.alarm) ? ST_ALARM : ST_NOT_HOMED;
                end else begin
                    nxt.drive  = DRIVE_NONE;
                    nxt.origin = 1'b0;
                    nxt.free   = 1'b0;
                    nxt.moving = 1'b0;
                    status     = ST_ACCEPTED;
                    if (i_item.check_limits) begin
                        if (i_item.alarm) begin
                            status = ST_ALARM;
                        end else if (s_tgt && s_others) begin
                            status = ST_LIMIT_ON;
                        end else if (s_tgt) begin
                            nxt.moving      = 1'b1;
                            nxt.move_target = i_item.target;
                            nxt.elapsed     = '0;
                        end else if (!s_others) begin
                            status = ST_LIMIT_OFF;
                        end else begin
                            nxt.moving      = 1'b1;
                            nxt.move_target = i_item.target;
                            nxt.elapsed     = '0;
                            nxt.drive       = tgt_drive;
                        end
                    end else begin
                        areset          = i_item.alarm;
                        nxt.moving      = 1'b1;
                        nxt.move_target = i_item.target;
                        nxt.elapsed     = '0;
                        nxt.drive       = tgt_drive;
                    end
                end
            end
            MODE_ORIGIN: begin
                nxt.moving = 1'b0;
                nxt.drive  = DRIVE_NONE;
                nxt.free   = 1'b0;
                nxt.origin = 1'b1;
                nxt.homed  = 1'b1;
                areset     = i_item.alarm;
                status     = ST_ACCEPTED;
            end
            MODE_FREE: begin
                nxt.homed = 1'b0;
                nxt.free  = 1'b1;
                status    = ST_ACCEPTED;
            end
            default: begin
                status = ST_IDLE;
            end
        endcase
    end

    assign o_state               = nxt;
    assign o_result.status       = status;
    assign o_result.which_target = which;
    assign o_result.drive_target = nxt.drive;
    assign o_result.drive_origin = nxt.origin;
    assign o_result.free_out     = nxt.free;
    assign o_result.alarm_reset  = areset;
    assign o_result.ready_ok     = nxt.homed & i_item.in_position;

endmodule

>>> rtl/core/rotary_indexer_move_supervisor.sv
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+-------------------------------
// in       | input     | i_in_valid/o_in_stall   | i_in_item  (t_in_item)
// out      | output    | o_out_valid/i_out_stall | o_out_item (t_out_item)
// cfg      | input     | i_cfg_valid/o_cfg_ready | i_cfg_data (motion limit)
//
// One request per cycle sustained while the output is not stalled: a request
// is held in the input register, is evaluated against the supervisor state and
// lands in the result register, which raises o_out_valid. Reset (i_rst_n low,
// synchronous) clears state, both valid flags and loads the motion limit with
// 5000. An output stall while o_out_valid is high holds the result register;
// a waiting input request then holds too, so o_in_stall rises in the same cycle.
module rotary_indexer_move_supervisor
    import rims_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [LIMIT_BITS-1:0] i_cfg_data
);

    logic                  r_in_valid;
    t_in_item              r_in;
    logic                  r_out_valid;
    t_out_item             r_out;
    t_state                r_state;
    logic [LIMIT_BITS-1:0] r_limit;

    t_state    n_state;
    t_out_item n_out;
    logic      advance;
    logic      take_in;

    rims_step u_step (
        .i_item   (r_in),
        .i_state  (r_state),
        .i_limit  (r_limit),
        .o_state  (n_state),
        .o_result (n_out)
    );

    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign take_in     = i_in_valid && !o_in_stall;
    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
            r_limit     <= LIMIT_RESET;
        end else begin
            if (take_in) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in <= i_in_item;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    a_idle_no_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.moving |-> r_state.drive == DRIVE_NONE)
        else $error("drive asserted while no move is monitored");

    a_origin_not_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.origin |-> !r_state.moving)
        else $error("origin drive and move monitoring both active");

    a_out_from_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result appeared without a request in the input register");

    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.drive_target <= DRIVE_MAX)
        else $error("drive target out of range");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(advance) && $past(i_rst_n) |-> $stable(r_state))
        else $error("supervisor state changed without a request");

endmodule
